// ----- hdl/grid_ring_rotation_macros.svh -----
// assertion macros for the ring rotation grid checker
`ifndef GRID_RING_ROTATION_MACROS_SVH
`define GRID_RING_ROTATION_MACROS_SVH

// next-edge implication, quiet while reset is high
`define GRR_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

// next-edge implication that also covers the reset cycles
`define GRR_ASSERT_NEXT_ALWAYS(label, clk, cond, expr, msg) \
   label: assert property (@(posedge clk) (cond) |=> (expr)) \
      else $error(msg);

`endif

// ----- hdl/grr_pkg.sv -----
// shared types and constants of the ring rotation grid
package grr_pkg;

   localparam int COORD_BITS       = 7;
   localparam int DIM_BITS         = 7;
   localparam int DEPTH_BITS       = 6;
   localparam int LEN_BITS         = 9;
   localparam int STORE_CMP_BITS   = 9;
   localparam int ROT_BITS         = 30;
   localparam int ROT_COUNT_BITS   = 5;
   localparam int INDEX_BITS       = 6;
   localparam int VALUE_BITS       = 32;
   localparam int CSR_INDEX_BITS   = 2;
   localparam int CSR_DATA_BITS    = 32;

   localparam int QUEUE_DEPTH      = 2;
   localparam int QUEUE_PTR_BITS   = 1;
   localparam int QUEUE_COUNT_BITS = 2;

   localparam int OUT_DEPTH        = 4;
   localparam int OUT_PTR_BITS     = 2;
   localparam int OUT_COUNT_BITS   = 3;
   localparam int CREDIT_BITS      = 4;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [DIM_BITS-1:0]   dim_type;
   typedef logic [LEN_BITS-1:0]   len_type;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_READ  = 1'b1
   } opcode_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ROW_COUNT      = 2'd0,
      CSR_COLUMN_COUNT   = 2'd1,
      CSR_ROTATION_COUNT = 2'd2
   } csr_index_type;

   // dimensions in use and sweep status
   typedef struct packed {
      logic    busy;
      dim_type rows;
      dim_type cols;
   } geom_type;

   // one classified item on its way to the back end
   typedef struct packed {
      opcode_type             op;
      logic                   ring_ok;
      logic                   store_ok;
      coord_type              row;
      coord_type              col;
      logic [DEPTH_BITS-1:0]  depth;
      coord_type              r2;
      coord_type              c2;
      len_type                h;
      len_type                hv;
      len_type                h2v;
      len_type                len;
      len_type                pos;
      logic [VALUE_BITS-1:0]  value;
   } entry_type;

endpackage

// ----- hdl/grid_ring_rotation.sv -----
// top level: word grid store read back through concentric ring rotation
// path of a read to its result (empty low): input register, item queue, mapping stage, memory data stage, result queue
// throughput: one item per cycle sustained while results are taken and no sweep runs, set
//   by the single memory port and the four-entry result queue that bounds reads in flight
// reset and every configuration transfer start a residue sweep, one bit of the rotation
//   count per cycle; full stays high during it, the grid store is not cleared
module grid_ring_rotation #(
   parameter int MAX_DIM   = 64,
   parameter int WORD_BITS = 32
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // item side
   input  logic                                    push,
   output logic                                    full,
   input  logic                                    req_opcode,
   input  logic [grr_pkg::INDEX_BITS-1:0]          req_row_index,
   input  logic [grr_pkg::INDEX_BITS-1:0]          req_column_index,
   input  logic signed [grr_pkg::VALUE_BITS-1:0]   req_cell_value,
   // result side
   output logic                                    empty,
   input  logic                                    pop,
   output logic signed [grr_pkg::VALUE_BITS-1:0]   rsp_rotated_value,
   // configuration side
   input  logic                                    valid,
   output logic                                    ready,
   input  logic [grr_pkg::CSR_INDEX_BITS-1:0]      csr_index,
   input  logic [grr_pkg::CSR_DATA_BITS-1:0]       csr_wdata
);
   import grr_pkg::*;

   geom_type                geom;
   logic                    queue_push, queue_full, queue_pop, queue_empty;
   entry_type               queue_entry, queue_head;
   logic [DEPTH_BITS-1:0]   lookup_depth;
   len_type                 lookup_residue;

   // registers and the rotation count reduced modulo each ring length
   grr_residue #(
      .MAX_DIM (MAX_DIM)
   ) u_residue (
      .clock          (clock),
      .reset          (reset),
      .valid          (valid),
      .ready          (ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .geom           (geom),
      .lookup_depth   (lookup_depth),
      .lookup_residue (lookup_residue)
   );

   // front end: takes the transfer, works out ring depth and place along the ring
   grr_front #(
      .MAX_DIM (MAX_DIM)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_opcode       (req_opcode),
      .req_row_index    (req_row_index),
      .req_column_index (req_column_index),
      .req_cell_value   (req_cell_value),
      .geom             (geom),
      .queue_full       (queue_full),
      .queue_push       (queue_push),
      .queue_entry      (queue_entry)
   );

   // decouples classification from memory access
   grr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (queue_push),
      .push_entry (queue_entry),
      .full       (queue_full),
      .pop        (queue_pop),
      .head       (queue_head),
      .empty      (queue_empty)
   );

   // back end: adds the residue, maps back to original cell, reads or writes the store
   grr_back #(
      .MAX_DIM   (MAX_DIM),
      .WORD_BITS (WORD_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .queue_empty       (queue_empty),
      .queue_head        (queue_head),
      .queue_pop         (queue_pop),
      .lookup_depth      (lookup_depth),
      .lookup_residue    (lookup_residue),
      .empty             (empty),
      .pop               (pop),
      .rsp_rotated_value (rsp_rotated_value)
   );

endmodule

// ----- hdl/grr_residue.sv -----
// configuration registers and per-ring residue sweep of the rotation count
module grr_residue #(
   parameter int MAX_DIM = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 valid,
   output logic                                 ready,
   input  logic [grr_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [grr_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   output grr_pkg::geom_type                    geom,
   input  logic [grr_pkg::DEPTH_BITS-1:0]       lookup_depth,
   output grr_pkg::len_type                     lookup_residue
);
   import grr_pkg::*;

   localparam int DIM_CAP   = (MAX_DIM < 128) ? MAX_DIM : 128;
   localparam int HALF      = DIM_CAP / 2;
   localparam int LANE_BITS = (HALF > 1) ? $clog2(HALF) : 1;
   localparam int LANES     = 2 ** LANE_BITS;
   localparam logic [STORE_CMP_BITS-1:0] MAX_DIM_W = STORE_CMP_BITS'(MAX_DIM);
   localparam logic [ROT_COUNT_BITS-1:0] LAST_BIT  = ROT_COUNT_BITS'(ROT_BITS - 1);

   dim_type                   row_count_ff, row_count_in;
   dim_type                   column_count_ff, column_count_in;
   logic [ROT_BITS-1:0]       rotation_count_ff, rotation_count_in;
   logic [ROT_BITS-1:0]       shift_ff, shift_in;
   logic [ROT_COUNT_BITS-1:0] bit_cnt_ff, bit_cnt_in;
   logic                      busy_ff, busy_in;
   len_type                   rem_ff [LANES];
   len_type                   rem_in [LANES];
   len_type                   lane_len [LANES];
   logic [LEN_BITS:0]         ext;
   logic [11:0]               perim;
   logic                      csr_write;

   assign ready     = 1'b1;
   assign csr_write = valid && ready;

   // dimensions above the store size fold to the store size
   assign geom.busy = busy_ff;
   assign geom.rows = ({2'b0, row_count_ff} > MAX_DIM_W) ? DIM_BITS'(MAX_DIM_W) : row_count_ff;
   assign geom.cols = ({2'b0, column_count_ff} > MAX_DIM_W) ?
                      DIM_BITS'(MAX_DIM_W) : column_count_ff;

   assign lookup_residue = rem_ff[lookup_depth[LANE_BITS-1:0]];

   // ring length of each depth, 2(m+n) - 4 - 8d
   always_comb begin
      perim = 12'({geom.rows, 1'b0}) + 12'({geom.cols, 1'b0});
      for (int i = 0; i < LANES; i++) begin
         lane_len[i] = (perim > 12'(4 + 8 * i)) ? LEN_BITS'(perim - 12'(4 + 8 * i))
                                                : LEN_BITS'(1);
      end
   end

   always_comb begin
      row_count_in      = row_count_ff;
      column_count_in   = column_count_ff;
      rotation_count_in = rotation_count_ff;
      shift_in          = shift_ff;
      bit_cnt_in        = bit_cnt_ff;
      busy_in           = busy_ff;
      ext               = '0;
      for (int i = 0; i < LANES; i++) begin
         rem_in[i] = rem_ff[i];
      end
      if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_ROW_COUNT: begin
               row_count_in = csr_wdata[DIM_BITS-1:0];
            end
            CSR_COLUMN_COUNT: begin
               column_count_in = csr_wdata[DIM_BITS-1:0];
            end
            CSR_ROTATION_COUNT: begin
               rotation_count_in = csr_wdata[ROT_BITS-1:0];
            end
            default: begin
            end
         endcase
         busy_in    = 1'b1;
         bit_cnt_in = '0;
         shift_in   = rotation_count_in;
         for (int i = 0; i < LANES; i++) begin
            rem_in[i] = '0;
         end
      end else if (busy_ff) begin
         // restoring remainder, one bit of the count per cycle in every lane
         for (int i = 0; i < LANES; i++) begin
            ext = {rem_ff[i], shift_ff[ROT_BITS-1]};
            rem_in[i] = (ext >= {1'b0, lane_len[i]}) ?
                        LEN_BITS'(ext - {1'b0, lane_len[i]}) : LEN_BITS'(ext);
         end
         shift_in = {shift_ff[ROT_BITS-2:0], 1'b0};
         if (bit_cnt_ff == LAST_BIT) begin
            busy_in = 1'b0;
         end else begin
            bit_cnt_in = bit_cnt_ff + ROT_COUNT_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff      <= DIM_BITS'(2);
         column_count_ff   <= DIM_BITS'(2);
         rotation_count_ff <= '0;
         shift_ff          <= '0;
         bit_cnt_ff        <= '0;
         busy_ff           <= 1'b1;
         for (int i = 0; i < LANES; i++) begin
            rem_ff[i] <= '0;
         end
      end else begin
         row_count_ff      <= row_count_in;
         column_count_ff   <= column_count_in;
         rotation_count_ff <= rotation_count_in;
         shift_ff          <= shift_in;
         bit_cnt_ff        <= bit_cnt_in;
         busy_ff           <= busy_in;
         for (int i = 0; i < LANES; i++) begin
            rem_ff[i] <= rem_in[i];
         end
      end
   end

endmodule

// ----- hdl/grr_front.sv -----
// input register and ring classification of each item
module grr_front #(
   parameter int MAX_DIM = 64
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    push,
   output logic                                    full,
   input  logic                                    req_opcode,
   input  logic [grr_pkg::INDEX_BITS-1:0]          req_row_index,
   input  logic [grr_pkg::INDEX_BITS-1:0]          req_column_index,
   input  logic signed [grr_pkg::VALUE_BITS-1:0]   req_cell_value,
   input  grr_pkg::geom_type                       geom,
   input  logic                                    queue_full,
   output logic                                    queue_push,
   output grr_pkg::entry_type                      queue_entry
);
   import grr_pkg::*;

   localparam logic [STORE_CMP_BITS-1:0] MAX_DIM_W = STORE_CMP_BITS'(MAX_DIM);

   logic                   front_valid_ff, front_valid_in;
   opcode_type             front_op_ff;
   logic [INDEX_BITS-1:0]  front_row_ff, front_col_ff;
   logic [VALUE_BITS-1:0]  front_value_ff;
   logic                   accept;

   coord_type r, c, m1r, n1c, near_a, near_b, d, r2, c2, h, v;
   len_type   hv, h2v, len, pos;
   logic      in_grid, ring_ok, store_ok;

   assign full           = geom.busy || (front_valid_ff && queue_full);
   assign accept         = push && !full;
   assign queue_push     = front_valid_ff && !queue_full;
   assign front_valid_in = accept || (front_valid_ff && queue_full);

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         front_op_ff    <= opcode_type'(req_opcode);
         front_row_ff   <= req_row_index;
         front_col_ff   <= req_column_index;
         front_value_ff <= req_cell_value;
      end
   end

   // depth is the distance to the nearest edge, then the place along the ring
   always_comb begin
      r       = {1'b0, front_row_ff};
      c       = {1'b0, front_col_ff};
      in_grid = (r < geom.rows) && (c < geom.cols);
      m1r     = geom.rows - COORD_BITS'(1) - r;
      n1c     = geom.cols - COORD_BITS'(1) - c;
      near_a  = (r < c) ? r : c;
      near_b  = (m1r < n1c) ? m1r : n1c;
      d       = (near_a < near_b) ? near_a : near_b;
      r2      = geom.rows - COORD_BITS'(1) - d;
      c2      = geom.cols - COORD_BITS'(1) - d;
      ring_ok = in_grid && (d < r2) && (d < c2);
      h       = c2 - d;
      v       = r2 - d;
      hv      = LEN_BITS'(h) + LEN_BITS'(v);
      h2v     = hv + LEN_BITS'(h);
      len     = LEN_BITS'({hv, 1'b0});
      if (r == d) begin
         pos = LEN_BITS'(c) - LEN_BITS'(d);
      end else if (c == c2) begin
         pos = LEN_BITS'(h) + LEN_BITS'(r) - LEN_BITS'(d);
      end else if (r == r2) begin
         pos = hv + LEN_BITS'(c2) - LEN_BITS'(c);
      end else begin
         pos = h2v + LEN_BITS'(r2) - LEN_BITS'(r);
      end
      store_ok = ({2'b0, r} < MAX_DIM_W) && ({2'b0, c} < MAX_DIM_W);
   end

   always_comb begin
      queue_entry.op       = front_op_ff;
      queue_entry.ring_ok  = ring_ok;
      queue_entry.store_ok = store_ok;
      queue_entry.row      = r;
      queue_entry.col      = c;
      queue_entry.depth    = DEPTH_BITS'(d);
      queue_entry.r2       = r2;
      queue_entry.c2       = c2;
      queue_entry.h        = LEN_BITS'(h);
      queue_entry.hv       = hv;
      queue_entry.h2v      = h2v;
      queue_entry.len      = len;
      queue_entry.pos      = pos;
      queue_entry.value    = front_value_ff;
   end

endmodule

// ----- hdl/grr_queue.sv -----
// short queue of classified items between front and back end
module grr_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  grr_pkg::entry_type   push_entry,
   output logic                 full,
   input  logic                 pop,
   output grr_pkg::entry_type   head,
   output logic                 empty
);
   import grr_pkg::*;

   entry_type                   slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_COUNT_BITS-1:0] count_ff, count_in;

   assign full  = (count_ff == QUEUE_COUNT_BITS'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QUEUE_PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + QUEUE_COUNT_BITS'(push) - QUEUE_COUNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- hdl/grr_back.sv -----
// ring position mapping, grid memory and result queue
module grr_back #(
   parameter int MAX_DIM   = 64,
   parameter int WORD_BITS = 32
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    queue_empty,
   input  grr_pkg::entry_type                      queue_head,
   output logic                                    queue_pop,
   output logic [grr_pkg::DEPTH_BITS-1:0]          lookup_depth,
   input  grr_pkg::len_type                        lookup_residue,
   output logic                                    empty,
   input  logic                                    pop,
   output logic signed [grr_pkg::VALUE_BITS-1:0]   rsp_rotated_value
);
   import grr_pkg::*;

   localparam int VB   = (WORD_BITS < VALUE_BITS) ? WORD_BITS : VALUE_BITS;
   localparam int ROWW = $clog2(MAX_DIM);
   localparam int SAW  = $clog2(MAX_DIM * MAX_DIM);

   // mapping stage
   logic                   a_valid_ff;
   opcode_type             a_op_ff;
   logic                   a_ring_ok_ff, a_store_ok_ff;
   coord_type              a_row_ff, a_col_ff, a_depth_ff, a_r2_ff, a_c2_ff;
   len_type                a_h_ff, a_hv_ff, a_h2v_ff, a_q_ff;
   logic [VALUE_BITS-1:0]  a_value_ff;

   // memory data stage
   logic                   m_valid_ff, m_valid_in;
   logic                   m_zero_ff;
   logic [WORD_BITS-1:0]   rdata_ff;
   logic [WORD_BITS-1:0]   store_mem [MAX_DIM * MAX_DIM];

   // result queue
   logic [VALUE_BITS-1:0]      out_mem_ff [OUT_DEPTH];
   logic [OUT_PTR_BITS-1:0]    out_wr_ff, out_wr_in, out_rd_ff, out_rd_in;
   logic [OUT_COUNT_BITS-1:0]  out_count_ff, out_count_in;
   logic                       out_pop;
   logic [VALUE_BITS-1:0]      out_data;

   logic [LEN_BITS:0]      q_sum;
   len_type                q;
   len_type                d9, map_row, map_col;
   coord_type              sel_row, sel_col;
   logic [8:0]             row_x, col_x;
   logic [SAW-1:0]         addr;
   logic                   sel_ok, a_read, a_write;
   logic [CREDIT_BITS-1:0] in_flight;
   logic [WORD_BITS-1:0]   wdata;

   assign lookup_depth = queue_head.depth;

   // reads in flight plus waiting results never exceed the result queue
   assign a_read    = a_valid_ff && (a_op_ff == OP_READ);
   assign a_write   = a_valid_ff && (a_op_ff == OP_WRITE);
   assign in_flight = CREDIT_BITS'(a_read) + CREDIT_BITS'(m_valid_ff) +
                      CREDIT_BITS'(out_count_ff);
   assign queue_pop = !queue_empty && (in_flight < CREDIT_BITS'(OUT_DEPTH));

   always_comb begin
      q_sum = {1'b0, queue_head.pos} + {1'b0, lookup_residue};
      q     = (q_sum >= {1'b0, queue_head.len}) ?
              LEN_BITS'(q_sum - {1'b0, queue_head.len}) : LEN_BITS'(q_sum);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= queue_pop;
      end
   end

   always_ff @(posedge clock) begin
      if (queue_pop) begin
         a_op_ff       <= queue_head.op;
         a_ring_ok_ff  <= queue_head.ring_ok;
         a_store_ok_ff <= queue_head.store_ok;
         a_row_ff      <= queue_head.row;
         a_col_ff      <= queue_head.col;
         a_depth_ff    <= COORD_BITS'(queue_head.depth);
         a_r2_ff       <= queue_head.r2;
         a_c2_ff       <= queue_head.c2;
         a_h_ff        <= queue_head.h;
         a_hv_ff       <= queue_head.hv;
         a_h2v_ff      <= queue_head.h2v;
         a_q_ff        <= q;
         a_value_ff    <= queue_head.value;
      end
   end

   // original coordinates of the element that lands at the rotated position
   always_comb begin
      d9 = LEN_BITS'(a_depth_ff);
      if (a_q_ff <= a_h_ff) begin
         map_row = d9;
         map_col = d9 + a_q_ff;
      end else if (a_q_ff <= a_hv_ff) begin
         map_row = d9 + a_q_ff - a_h_ff;
         map_col = LEN_BITS'(a_c2_ff);
      end else if (a_q_ff <= a_h2v_ff) begin
         map_row = LEN_BITS'(a_r2_ff);
         map_col = LEN_BITS'(a_c2_ff) - (a_q_ff - a_hv_ff);
      end else begin
         map_row = LEN_BITS'(a_r2_ff) - (a_q_ff - a_h2v_ff);
         map_col = d9;
      end
      // writes always land at their own cell, only reads are remapped
      sel_row = (a_ring_ok_ff && a_read) ? COORD_BITS'(map_row) : a_row_ff;
      sel_col = (a_ring_ok_ff && a_read) ? COORD_BITS'(map_col) : a_col_ff;
      sel_ok  = a_ring_ok_ff || a_store_ok_ff;
      row_x   = {2'b0, sel_row};
      col_x   = {2'b0, sel_col};
      addr    = SAW'(row_x[ROWW-1:0]) * SAW'(MAX_DIM) + SAW'(col_x[ROWW-1:0]);
      wdata   = WORD_BITS'(a_value_ff[VB-1:0]);
   end

   always_ff @(posedge clock) begin
      if (a_write && a_store_ok_ff) begin
         store_mem[addr] <= wdata;
      end
      rdata_ff  <= store_mem[addr];
      m_zero_ff <= !sel_ok;
   end

   assign m_valid_in = a_read;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else begin
         m_valid_ff <= m_valid_in;
      end
   end

   // cells beyond the store read as zero
   assign out_data = m_zero_ff ? '0 : VALUE_BITS'(rdata_ff[VB-1:0]);
   assign empty    = (out_count_ff == '0);
   assign out_pop  = pop && !empty;
   assign rsp_rotated_value = $signed(out_mem_ff[out_rd_ff]);

   always_comb begin
      out_wr_in    = m_valid_ff ? out_wr_ff + OUT_PTR_BITS'(1) : out_wr_ff;
      out_rd_in    = out_pop ? out_rd_ff + OUT_PTR_BITS'(1) : out_rd_ff;
      out_count_in = out_count_ff + OUT_COUNT_BITS'(m_valid_ff) - OUT_COUNT_BITS'(out_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_wr_ff    <= '0;
         out_rd_ff    <= '0;
         out_count_ff <= '0;
      end else begin
         out_wr_ff    <= out_wr_in;
         out_rd_ff    <= out_rd_in;
         out_count_ff <= out_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (m_valid_ff) begin
         out_mem_ff[out_wr_ff] <= out_data;
      end
   end

endmodule

// ----- hdl/grr_checker.sv -----
// port-level checks of the ring rotation grid and their binding
`include "grid_ring_rotation_macros.svh"

module grr_checker (
   input logic clock,
   input logic reset,
   input logic push,
   input logic full,
   input logic empty,
   input logic pop,
   input logic valid,
   input logic ready
);

   // reset leaves no result and starts the residue sweep
   `GRR_ASSERT_NEXT_ALWAYS(a_reset_state, clock, reset, full && empty, "reset state wrong")

   // a configuration transfer holds off items while residues are rebuilt
   `GRR_ASSERT_NEXT(a_cfg_holds_input, clock, reset, valid && ready, full, "input open in sweep")

   // with nothing new arriving the input side cannot fill up
   `GRR_ASSERT_NEXT(a_full_cause, clock, reset, !full && !push && !valid, !full, "full spurious")

   // a waiting result only leaves through a transfer
   `GRR_ASSERT_NEXT(a_result_kept, clock, reset, !empty && !pop, !empty, "result lost")

endmodule

bind grid_ring_rotation grr_checker u_grr_checker (
   .clock (clock),
   .reset (reset),
   .push  (push),
   .full  (full),
   .empty (empty),
   .pop   (pop),
   .valid (valid),
   .ready (ready)
);
